>>> sv/lfa_pkg.sv
// ----------------------------------------------------------------------------
// lfa_pkg: shared types and constants of the line sensor frame averager
// Holds the result item layout, the output push request, the queue status and fixed constants.
// ----------------------------------------------------------------------------
package lfa_pkg;

  // Width of the converter sample and of an emitted word
  localparam int unsigned WORD_W = 16;
  // Width of the average_count register
  localparam int unsigned CFG_W = 11;
  // Reset value of average_count
  localparam logic [CFG_W-1:0] COUNT_RESET = 11'd50;
  // Word that marks the start of an averaged frame
  localparam logic [WORD_W-1:0] HEADER_WORD = 16'hFFFF;

  // One result item
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              is_header;
    logic              last;
  } out_item_t;

  // Push request from the sequencer to the output queue
  typedef struct packed {
    logic valid;
    logic with_header;
  } push_req_t;

  // Output queue status toward the sequencer
  typedef struct packed {
    logic empty;
    logic pop;
  } queue_stat_t;

endpackage

>>> sv/lfa_sum_mem.sv
// ----------------------------------------------------------------------------
// lfa_sum_mem: per-pixel accumulator storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lfa_sum_mem #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned DATA_W = 26
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write the accumulator back
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the accumulator, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lfa_divider.sv
// ----------------------------------------------------------------------------
// lfa_divider: serial restoring divider
// Produces one quotient bit per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module lfa_divider #(
  parameter int unsigned NUM_W = 26,
  parameter int unsigned DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(NUM_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  den;
  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W:0]    trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and compare
  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    fits  = trial >= {1'b0, den};
  end

  // Control: count the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (start) begin
      den <= divisor;
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> sv/lfa_out_queue.sv
// ----------------------------------------------------------------------------
// lfa_out_queue: two-entry output queue
// Holds a header and a pixel word, or a pixel word alone, for the receiver.
// ----------------------------------------------------------------------------
module lfa_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  lfa_pkg::push_req_t push,
  input  lfa_pkg::out_item_t pix,
  output lfa_pkg::queue_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output lfa_pkg::out_item_t head
);

  import lfa_pkg::*;

  out_item_t  slot0;
  out_item_t  slot1;
  logic [1:0] fill;
  logic       pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = fill != 2'd0;
  assign head       = slot0;
  assign stat.empty = fill == 2'd0;
  assign stat.pop   = pop;

  // Fill count; a push is only made into an empty queue
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (push.valid) begin
      fill <= push.with_header ? 2'd2 : 2'd1;
    end else if (pop) begin
      fill <= fill - 2'd1;
    end
  end

  // Load entries, advance on transfer
  always_ff @(posedge clk) begin
    if (push.valid) begin
      if (push.with_header) begin
        slot0 <= '{word: HEADER_WORD, is_header: 1'b1, last: 1'b0};
        slot1 <= pix;
      end else begin
        slot0 <= pix;
      end
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

>>> sv/line_sensor_frame_averager.sv
// ----------------------------------------------------------------------------
// line_sensor_frame_averager: boxcar averaging over whole sensor frames
// Sums one sample per pixel into per-pixel accumulators and emits the mean
// of each pixel once every average_count frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, sample) takes one sample per pixel in
//   line order. Output channel (out_valid/out_ready, word/is_header/last)
//   gives, in the final frame of a group, a 0xFFFF header before pixel zero
//   and one mean per pixel, last set on the final pixel.
//   cfg_we/cfg_wdata write average_count (0 acts as 1, clamps at
//   MAX_AVERAGE); write it only while the block is idle.
// Timing:
//   A sample in a summing frame is read at transfer and written back in the
//   load state. A sample in an emitting frame passes the load, divide and
//   push states; the divide state lasts until the serial divider, which yields
//   one quotient bit per cycle, is done; the first word becomes visible as
//   in_ready rises again. in_ready is low while a sample is in work.
// Reset and stall:
//   Reset zeroes the pixel and frame counters; the accumulators read as zero
//   during the first frame after reset, so no clearing pass is needed.
//   A stalled receiver holds the two-entry output queue; the next sample is
//   still taken and summed, and an emitting sample waits for the queue to
//   drain before it writes back.
// ----------------------------------------------------------------------------
module line_sensor_frame_averager #(
  parameter int unsigned LINE_PIXELS = 512,
  parameter int unsigned MAX_AVERAGE = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lfa_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               word,
  output logic                      is_header,
  output logic                      last
);

  import lfa_pkg::*;

  localparam int unsigned POS_W = $clog2(LINE_PIXELS);
  localparam int unsigned CNT_W = $clog2(MAX_AVERAGE + 1);
  localparam int unsigned FIG_W = $clog2(MAX_AVERAGE);
  localparam int unsigned SUM_W = WORD_W + $clog2(MAX_AVERAGE);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_PUSH = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CFG_W-1:0] average_count;
  logic [POS_W-1:0] pixel_position;
  logic [FIG_W-1:0] frame_in_group;
  logic             fresh;
  logic [WORD_W-1:0] sample_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] count_r;
  logic             final_frame_r;
  logic             fresh_r;

  logic [CNT_W-1:0] eff_count;
  logic [CNT_W:0]   fig_plus;
  logic             final_frame;
  logic             accept;
  logic [SUM_W-1:0] mem_rdata;
  logic [SUM_W-1:0] total;
  logic             mem_we;
  logic [SUM_W-1:0] mem_wdata;
  logic             div_done;
  logic [SUM_W-1:0] quotient;
  logic             final_pixel;
  logic             retire;
  push_req_t        push;
  out_item_t        pix;
  out_item_t        head;
  queue_stat_t      qstat;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      average_count <= COUNT_RESET;
    end else if (cfg_we) begin
      average_count <= cfg_wdata;
    end
  end

  // Effective count: zero acts as one, clamp at the maximum
  always_comb begin
    if (average_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(average_count) > 32'(MAX_AVERAGE)) begin
      eff_count = CNT_W'(MAX_AVERAGE);
    end else begin
      eff_count = CNT_W'(average_count);
    end
    fig_plus    = (CNT_W + 1)'(frame_in_group) + (CNT_W + 1)'(1);
    final_frame = fig_plus >= (CNT_W + 1)'(eff_count);
  end

  assign accept      = in_valid && in_ready;
  assign in_ready    = state == S_IDLE;
  assign final_pixel = pos_r == POS_W'(LINE_PIXELS - 1);
  assign total       = SUM_W'(sample_r) + (fresh_r ? '0 : mem_rdata);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_LOAD;
      S_LOAD: state_next = final_frame_r ? S_DIV : S_IDLE;
      S_DIV:  if (div_done) state_next = S_PUSH;
      S_PUSH: if (qstat.empty) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Write back and push: running total in a summing frame, zero once emitted
  always_comb begin
    retire    = (state == S_LOAD && !final_frame_r) || (state == S_PUSH && qstat.empty);
    mem_we    = retire;
    mem_wdata = final_frame_r ? '0 : total;
    push.valid       = state == S_PUSH && qstat.empty;
    push.with_header = pos_r == '0;
    pix.word         = quotient[WORD_W-1:0];
    pix.is_header    = 1'b0;
    pix.last         = final_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the sample and the decisions at transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r      <= sample;
      pos_r         <= pixel_position;
      count_r       <= eff_count;
      final_frame_r <= final_frame;
      fresh_r       <= fresh;
    end
  end

  // Advance pixel and frame counters when a sample retires
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      frame_in_group <= '0;
      fresh          <= 1'b1;
    end else if (retire) begin
      if (final_pixel) begin
        pixel_position <= '0;
        fresh          <= 1'b0;
        frame_in_group <= final_frame_r ? '0 : frame_in_group + FIG_W'(1);
      end else begin
        pixel_position <= pixel_position + POS_W'(1);
      end
    end
  end

  lfa_sum_mem #(
    .DEPTH  (LINE_PIXELS),
    .DATA_W (SUM_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pos_r),
    .wdata (mem_wdata),
    .raddr (pixel_position),
    .rdata (mem_rdata)
  );

  lfa_divider #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD && final_frame_r),
    .dividend (total),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  lfa_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pix       (pix),
    .stat      (qstat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign word      = head.word;
  assign is_header = head.is_header;
  assign last      = head.last;

  // Checks
  a_div_only_final: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> final_frame_r)
    else $error("divider running for a summing frame");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second sample taken while one is in work");

  a_push_into_empty: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> qstat.empty && !qstat.pop)
    else $error("push into a queue that still holds results");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_header_at_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    push.valid && push.with_header |-> !final_pixel || POS_W'(LINE_PIXELS - 1) == '0)
    else $error("header pushed with the final pixel");

endmodule
